### src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

### src/twcw_pkg.sv
package twcw_pkg;

    localparam int WINDOWS      = 16;
    localparam int LINE_COLUMNS = 32;
    localparam int LINE_ROWS    = 24;
    localparam int TAB_WIDTH    = 4;

    localparam int WIN_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 2;
    localparam int TILE_W  = 10;
    localparam int COL_W   = $clog2(LINE_COLUMNS);
    localparam int FILL_W  = $clog2(LINE_COLUMNS + 1);
    localparam int ROW_W   = 5;
    localparam int COLOR_SHIFT = 7;

    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_PCT   = 8'd37;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_THREE = 8'd51;

    localparam logic [1:0] TILE_CHAR  = 2'd0;
    localparam logic [1:0] TILE_PCT   = 2'd1;
    localparam logic [1:0] TILE_SPACE = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clr_pending;
        logic       set_pending;
        logic       set_color;
        logic       emit_write;
        logic       emit_flush;
        logic       last;
        logic [1:0] tile_sel;
        logic       writeback;
    } cmd_t;

    typedef struct packed {
        logic pending;
        logic is_digit;
        logic is_pct;
        logic is_tab;
        logic is_nl;
        logic last_text;
        logic fill_full;
        logic next_full;
        logic next_tab_stop;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic              kind;
        logic [WIN_W-1:0]  window;
        logic [COL_W-1:0]  column;
        logic [TILE_W-1:0] tile;
        logic [ROW_W-1:0]  row;
        logic [FILL_W-1:0] count;
        logic              scroll;
        logic              last;
    } res_t;

endpackage

### src/text_window_char_writer.sv
// Writes formatted text into per-window line buffers, one character per input transfer.
// Each transfer carries the window and the character; the block keeps the color, row,
// line fill and a pending-percent mark for every window, and answers with zero to six
// output transfers: character writes (tuser 0) and line flushes (tuser 1), the final one
// of each input marked by tlast. The marks %0 to %3 set the color and produce nothing.
// The controller handles one character at a time. A color mark passes through the decide
// and write-back states, a percent that is held for the next character through decide,
// dispatch and write-back; a newline emits a flush, a plain character a write and a tab
// one space write per column up to the next tab stop. A held percent that no digit follows
// is written out before the character, and an output waiting on m_tready stalls the controller.
// A new input is taken once the previous window state has been written back.
module text_window_char_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // window[3:0], char_code[11:4], zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // out_window, column, tile_code, row, line_count, scroll_first, zero
    output logic        m_tuser,  // kind
    output logic        m_tlast
);
    import twcw_pkg::*;

    cmd_t cmd;
    sts_t sts;
    res_t res;

    twcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .ready    (s_tready),
        .cmd      (cmd)
    );

    twcw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_window (s_tdata[WIN_W-1:0]),
        .in_char   (s_tdata[WIN_W+CHAR_W-1:WIN_W]),
        .in_last   (s_tlast),
        .m_tready  (m_tready),
        .sts       (sts),
        .out_valid (m_tvalid),
        .res       (res)
    );

    assign m_tdata = {1'b0, res.scroll, res.count, res.row, res.tile, res.column, res.window};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

### src/twcw_ctrl.sv
`include "assert_macros.svh"

module twcw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  twcw_pkg::sts_t sts,
    output logic           ready,
    output twcw_pkg::cmd_t cmd
);
    import twcw_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECIDE   = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_CHAR     = 3'd3;
    localparam logic [2:0] ST_POST     = 3'd4;
    localparam logic [2:0] ST_TAB      = 3'd5;
    localparam logic [2:0] ST_NL       = 3'd6;
    localparam logic [2:0] ST_WB       = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       phase1_reg;
    logic       phase1_next;
    logic       more;

    // A deferred percent is written first; the current character may still follow it.
    assign more  = phase1_reg && !(sts.is_pct && !sts.last_text);
    assign ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        phase1_next = phase1_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.pending)
                begin
                    cmd.clr_pending = 1'b1;
                    if (sts.is_digit)
                    begin
                        cmd.set_color = 1'b1;
                        state_next    = ST_WB;
                    end
                    else
                    begin
                        phase1_next = 1'b1;
                        state_next  = ST_CHAR;
                    end
                end
                else
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                phase1_next = 1'b0;
                if (sts.is_pct && !sts.last_text)
                begin
                    cmd.set_pending = 1'b1;
                    state_next      = ST_WB;
                end
                else if (sts.is_tab)
                begin
                    state_next = ST_TAB;
                end
                else if (sts.is_nl)
                begin
                    state_next = ST_NL;
                end
                else
                begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (sts.out_free)
                begin
                    if (sts.fill_full)
                    begin
                        cmd.emit_flush = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_write = 1'b1;
                        cmd.tile_sel   = phase1_reg ? TILE_PCT : TILE_CHAR;
                        cmd.last       = !sts.next_full && !more;
                        state_next     = ST_POST;
                    end
                end
            end
            ST_POST:
            begin
                if (sts.fill_full)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_flush = 1'b1;
                        cmd.last       = !more;
                        state_next     = phase1_reg ? ST_DISPATCH : ST_WB;
                    end
                end
                else
                begin
                    state_next = phase1_reg ? ST_DISPATCH : ST_WB;
                end
            end
            ST_TAB:
            begin
                if (sts.out_free)
                begin
                    if (sts.fill_full)
                    begin
                        cmd.emit_flush = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_write = 1'b1;
                        cmd.tile_sel   = TILE_SPACE;
                        cmd.last       = !sts.next_full && sts.next_tab_stop && !more;
                        if (sts.next_tab_stop || sts.next_full)
                        begin
                            state_next = ST_POST;
                        end
                    end
                end
            end
            ST_NL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    cmd.last       = !more;
                    state_next     = ST_WB;
                end
            end
            ST_WB:
            begin
                cmd.writeback = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase1_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase1_reg <= phase1_next;
        end
    end

    `ASSERT_ALWAYS(a_single_emit, !(cmd.emit_write && cmd.emit_flush), "write and flush at once")
    `ASSERT_IMPLY(a_emit_free, cmd.emit_write || cmd.emit_flush, sts.out_free, "emit into full output")
    `ASSERT_IMPLY(a_idle_quiet, ready, !(cmd.emit_write || cmd.emit_flush || cmd.writeback), "idle active")

endmodule

### src/twcw_datapath.sv
`include "assert_macros.svh"

module twcw_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  twcw_pkg::cmd_t               cmd,
    input  logic [twcw_pkg::WIN_W-1:0]   in_window,
    input  logic [twcw_pkg::CHAR_W-1:0]  in_char,
    input  logic                         in_last,
    input  logic                         m_tready,
    output twcw_pkg::sts_t               sts,
    output logic                         out_valid,
    output twcw_pkg::res_t               res
);
    import twcw_pkg::*;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LINE_COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LIMIT = ROW_W'(LINE_ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(LINE_ROWS - 1);

    logic [COLOR_W-1:0] color_mem [WINDOWS];
    logic [ROW_W-1:0]   row_mem   [WINDOWS];
    logic [FILL_W-1:0]  fill_mem  [WINDOWS];
    logic               pend_mem  [WINDOWS];

    logic [WIN_W-1:0]   win_reg,   win_next;
    logic [CHAR_W-1:0]  char_reg,  char_next;
    logic               lastt_reg, lastt_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [ROW_W-1:0]   row_reg,   row_next;
    logic [FILL_W-1:0]  fill_reg,  fill_next;
    logic               pend_reg,  pend_next;
    logic               ovalid_reg, ovalid_next;
    res_t               res_reg,   res_next;

    logic [FILL_W-1:0]  fill_inc;
    logic [ROW_W-1:0]   row_eff;
    logic [TILE_W-1:0]  color_base;
    logic [TILE_W-1:0]  tile_val;

    assign fill_inc   = fill_reg + FILL_W'(1);
    assign row_eff    = (row_reg >= ROW_LIMIT) ? ROW_LAST : row_reg;
    assign color_base = TILE_W'(color_reg) << COLOR_SHIFT;

    always_comb
    begin
        case (cmd.tile_sel)
            TILE_PCT:   tile_val = color_base + TILE_W'(CHAR_PCT);
            TILE_SPACE: tile_val = TILE_W'(CHAR_SPACE);
            default:    tile_val = color_base + TILE_W'(char_reg);
        endcase
    end

    always_comb
    begin
        sts.pending       = pend_reg;
        sts.is_digit      = char_reg inside {[CHAR_ZERO:CHAR_THREE]};
        sts.is_pct        = (char_reg == CHAR_PCT);
        sts.is_tab        = (char_reg == CHAR_TAB);
        sts.is_nl         = (char_reg == CHAR_NL);
        sts.last_text     = lastt_reg;
        sts.fill_full     = (fill_reg >= FILL_FULL);
        sts.next_full     = (fill_inc >= FILL_FULL);
        sts.next_tab_stop = ((fill_inc % TAB_WIDTH) == 0);
        sts.out_free      = !ovalid_reg || m_tready;
    end

    always_comb
    begin
        win_next    = win_reg;
        char_next   = char_reg;
        lastt_next  = lastt_reg;
        color_next  = color_reg;
        row_next    = row_reg;
        fill_next   = fill_reg;
        pend_next   = pend_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && !m_tready;
        if (cmd.load)
        begin
            win_next   = in_window;
            char_next  = in_char;
            lastt_next = in_last;
            color_next = color_mem[in_window];
            row_next   = row_mem[in_window];
            fill_next  = fill_mem[in_window];
            pend_next  = pend_mem[in_window];
        end
        if (cmd.clr_pending)
        begin
            pend_next = 1'b0;
        end
        if (cmd.set_pending)
        begin
            pend_next = 1'b1;
        end
        if (cmd.set_color)
        begin
            color_next = COLOR_W'(char_reg - CHAR_ZERO);
        end
        if (cmd.emit_write)
        begin
            res_next.kind   = 1'b0;
            res_next.window = win_reg;
            res_next.column = fill_reg[COL_W-1:0];
            res_next.tile   = tile_val;
            res_next.row    = '0;
            res_next.count  = '0;
            res_next.scroll = 1'b0;
            res_next.last   = cmd.last;
            ovalid_next     = 1'b1;
            fill_next       = fill_inc;
        end
        if (cmd.emit_flush)
        begin
            res_next.kind   = 1'b1;
            res_next.window = win_reg;
            res_next.column = '0;
            res_next.tile   = '0;
            res_next.row    = row_eff;
            res_next.count  = fill_reg;
            res_next.scroll = (row_reg >= ROW_LIMIT);
            res_next.last   = cmd.last;
            ovalid_next     = 1'b1;
            row_next        = row_eff + ROW_W'(1);
            fill_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            char_reg   <= '0;
            lastt_reg  <= 1'b0;
            color_reg  <= '0;
            row_reg    <= '0;
            fill_reg   <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            win_reg    <= win_next;
            char_reg   <= char_next;
            lastt_reg  <= lastt_next;
            color_reg  <= color_next;
            row_reg    <= row_next;
            fill_reg   <= fill_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOWS; i++)
            begin
                color_mem[i] <= '0;
                row_mem[i]   <= '0;
                fill_mem[i]  <= '0;
                pend_mem[i]  <= 1'b0;
            end
        end
        else if (cmd.writeback)
        begin
            color_mem[win_reg] <= color_reg;
            row_mem[win_reg]   <= row_reg;
            fill_mem[win_reg]  <= fill_reg;
            pend_mem[win_reg]  <= pend_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign res       = res_reg;

    `ASSERT_ALWAYS(a_fill_range, fill_reg <= FILL_FULL, "line fill beyond line length")
    `ASSERT_IMPLY(a_flush_row, ovalid_reg && res_reg.kind, res_reg.row < ROW_LIMIT, "flush row out of range")
    `ASSERT_IMPLY(a_out_hold, ovalid_reg && !m_tready, ovalid_next, "waiting result dropped")

endmodule

### tb/text_window_char_writer_tb.sv
class window_text_scoreboard;

    twcw_pkg::res_t screen_ops_q[$];
    logic [twcw_pkg::COLOR_W-1:0] win_color [twcw_pkg::WINDOWS];
    logic [twcw_pkg::ROW_W-1:0]   win_row   [twcw_pkg::WINDOWS];
    logic [twcw_pkg::FILL_W-1:0]  win_fill  [twcw_pkg::WINDOWS];
    bit                           win_pct   [twcw_pkg::WINDOWS];
    int                           errors;

    function new();
        for (int i = 0; i < twcw_pkg::WINDOWS; i++)
        begin
            win_color[i] = '0;
            win_row[i]   = '0;
            win_fill[i]  = '0;
            win_pct[i]   = 1'b0;
        end
        errors = 0;
    endfunction

    function int outstanding();
        return screen_ops_q.size();
    endfunction

    function void push_op(logic kind, int w, int col, int tile, int row, int cnt, logic scroll);
        twcw_pkg::res_t r;
        r.kind   = kind;
        r.window = w[twcw_pkg::WIN_W-1:0];
        r.column = col[twcw_pkg::COL_W-1:0];
        r.tile   = tile[twcw_pkg::TILE_W-1:0];
        r.row    = row[twcw_pkg::ROW_W-1:0];
        r.count  = cnt[twcw_pkg::FILL_W-1:0];
        r.scroll = scroll;
        r.last   = 1'b0;
        screen_ops_q.push_back(r);
    endfunction

    function void flush_line(int w);
        int   r;
        logic sc;
        r  = int'(win_row[w]);
        sc = 1'b0;
        if (r >= twcw_pkg::LINE_ROWS)
        begin
            sc = 1'b1;
            r  = twcw_pkg::LINE_ROWS - 1;
        end
        push_op(1'b1, w, 0, 0, r, int'(win_fill[w]), sc);
        r           = r + 1;
        win_row[w]  = r[twcw_pkg::ROW_W-1:0];
        win_fill[w] = '0;
    endfunction

    function void write_tile(int w, int tile);
        int f;
        push_op(1'b0, w, int'(win_fill[w]), tile, 0, 0, 1'b0);
        f           = int'(win_fill[w]) + 1;
        win_fill[w] = f[twcw_pkg::FILL_W-1:0];
    endfunction

    function void render_char(int w, logic [7:0] c);
        int spaces;
        if (c == twcw_pkg::CHAR_NL)
        begin
            flush_line(w);
            return;
        end
        if (win_fill[w] >= twcw_pkg::LINE_COLUMNS)
            flush_line(w);
        if (c == twcw_pkg::CHAR_TAB)
        begin
            spaces = twcw_pkg::TAB_WIDTH - (int'(win_fill[w]) % twcw_pkg::TAB_WIDTH);
            while (spaces > 0 && win_fill[w] < twcw_pkg::LINE_COLUMNS)
            begin
                write_tile(w, int'(twcw_pkg::CHAR_SPACE));
                spaces--;
            end
        end
        else
        begin
            write_tile(w, int'(c) + (int'(win_color[w]) << twcw_pkg::COLOR_SHIFT));
        end
        if (win_fill[w] >= twcw_pkg::LINE_COLUMNS)
            flush_line(w);
    endfunction

    // Called once per accepted input transfer.
    function void note_char(int w, logic [7:0] c, logic eot);
        int             start;
        logic [7:0]     digit;
        twcw_pkg::res_t tail;
        start = screen_ops_q.size();
        if (w >= twcw_pkg::WINDOWS)
            return;
        if (win_pct[w])
        begin
            win_pct[w] = 1'b0;
            if (c >= twcw_pkg::CHAR_ZERO && c <= twcw_pkg::CHAR_THREE)
            begin
                digit        = c - twcw_pkg::CHAR_ZERO;
                win_color[w] = digit[twcw_pkg::COLOR_W-1:0];
                return;
            end
            render_char(w, twcw_pkg::CHAR_PCT);
        end
        if (c == twcw_pkg::CHAR_PCT && !eot)
            win_pct[w] = 1'b1;
        else
            render_char(w, c);
        if (screen_ops_q.size() > start)
        begin
            tail = screen_ops_q.pop_back();
            tail.last = 1'b1;
            screen_ops_q.push_back(tail);
        end
    endfunction

    function void compare_field(string name, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
        end
    endfunction

    // Called once per accepted output transfer.
    function void check_screen_op(twcw_pkg::res_t got);
        twcw_pkg::res_t exp_r;
        if (screen_ops_q.size() == 0)
        begin
            errors++;
            $display("%0t unexpected output transfer: expected none, actual %h", $time, got);
            return;
        end
        exp_r = screen_ops_q.pop_front();
        compare_field("kind", int'(exp_r.kind), int'(got.kind));
        compare_field("out_window", int'(exp_r.window), int'(got.window));
        compare_field("column", int'(exp_r.column), int'(got.column));
        compare_field("tile_code", int'(exp_r.tile), int'(got.tile));
        compare_field("row", int'(exp_r.row), int'(got.row));
        compare_field("line_count", int'(exp_r.count), int'(got.count));
        compare_field("scroll_first", int'(exp_r.scroll), int'(got.scroll));
        compare_field("last", int'(exp_r.last), int'(got.last));
    endfunction

endclass

module text_window_char_writer_tb;

    import twcw_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    window_text_scoreboard sb;
    int src_idle;
    int sink_stall;
    int chars_sent;
    int quiet_cycles;

    text_window_char_writer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_char(input int w, input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, c, 4'(w)};
        s_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_char(w, c, eot);
        chars_sent++;
    endtask

    task automatic send_text();
        int         len;
        int         w;
        int         p;
        bit         noisy;
        logic [7:0] c;
        len   = $urandom_range(1, 12);
        w     = ($urandom_range(99) < 60) ? 0 : $urandom_range(WINDOWS - 1);
        noisy = ($urandom_range(99) < 10);
        for (int i = 0; i < len; i++)
        begin
            p = $urandom_range(99);
            if (noisy)
                send_char(w, 8'($urandom_range(255)), i == len - 1);
            else if (p < 22)
                send_char(w, CHAR_NL, i == len - 1);
            else if (p < 32)
                send_char(w, CHAR_TAB, i == len - 1);
            else if (p < 42)
            begin
                send_char(w, CHAR_PCT, 1'b0);
                if ($urandom_range(99) < 75)
                    c = CHAR_ZERO + 8'($urandom_range(3));
                else
                    c = 8'($urandom_range(255));
                send_char(w, c, i == len - 1);
            end
            else if (p < 47)
                send_char(w, CHAR_PCT, i == len - 1);
            else if (p < 75)
                send_char(w, 8'($urandom_range(32, 126)), i == len - 1);
            else
                send_char(w, 8'($urandom_range(255)), i == len - 1);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_screen_op({m_tuser, m_tdata[3:0], m_tdata[8:4], m_tdata[18:9],
                                    m_tdata[23:19], m_tdata[29:24], m_tdata[30], m_tlast});
            m_tready <= ($urandom_range(99) >= sink_stall);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL text_window_char_writer");
            $finish;
        end
    end

    initial
    begin
        sb           = new();
        src_idle     = 21;
        sink_stall   = 66;
        chars_sent   = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_char(3, 8'd0, 1'b0);
        send_char(3, 8'd255, 1'b0);
        send_char(3, CHAR_PCT, 1'b0);
        send_char(3, CHAR_ZERO + 8'd1, 1'b0);
        send_char(3, "A", 1'b0);
        send_char(3, CHAR_PCT, 1'b0);
        send_char(3, CHAR_THREE, 1'b0);
        send_char(3, CHAR_TAB, 1'b0);
        send_char(3, CHAR_TAB, 1'b0);
        send_char(3, CHAR_PCT, 1'b0);
        send_char(3, "x", 1'b0);
        send_char(3, CHAR_PCT, 1'b0);
        send_char(3, CHAR_PCT, 1'b0);
        send_char(3, CHAR_ZERO + 8'd2, 1'b0);
        send_char(3, CHAR_PCT, 1'b1);
        send_char(3, CHAR_NL, 1'b0);
        send_char(3, CHAR_NL, 1'b1);
        send_char(3, CHAR_TAB, 1'b1);
        send_char(15, "q", 1'b0);
        send_char(15, CHAR_TAB, 1'b1);
        send_char(0, CHAR_PCT, 1'b0);
        send_char(0, CHAR_ZERO, 1'b1);

        while (chars_sent < 80)
            send_text();
        src_idle   = 66;
        sink_stall = 21;
        while (chars_sent < 150)
            send_text();
        src_idle   = 0;
        sink_stall = 0;
        while (chars_sent < 222)
            send_text();
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS text_window_char_writer");
        else
            $display("FAIL text_window_char_writer");
        $finish;
    end

endmodule
